// ----- rtl/core/y86_pkg.sv -----
// ----------------------------------------------------------------------------
// y86_pkg - shared definitions for the Y86-64 execute stage
// Instruction, function, status and register codes, plus the flag type.
// ----------------------------------------------------------------------------
package y86_pkg;

	localparam int WORD_W = 64;

	// Instruction codes (icode).
	localparam logic [3:0] I_HALT   = 4'd0;
	localparam logic [3:0] I_NOP    = 4'd1;
	localparam logic [3:0] I_RRMOVQ = 4'd2;
	localparam logic [3:0] I_IRMOVQ = 4'd3;
	localparam logic [3:0] I_RMMOVQ = 4'd4;
	localparam logic [3:0] I_MRMOVQ = 4'd5;
	localparam logic [3:0] I_OPQ    = 4'd6;
	localparam logic [3:0] I_JXX    = 4'd7;
	localparam logic [3:0] I_CALL   = 4'd8;
	localparam logic [3:0] I_RET    = 4'd9;
	localparam logic [3:0] I_PUSHQ  = 4'd10;
	localparam logic [3:0] I_POPQ   = 4'd11;

	// ALU function codes.
	localparam logic [3:0] ALU_ADD = 4'd0;
	localparam logic [3:0] ALU_SUB = 4'd1;
	localparam logic [3:0] ALU_AND = 4'd2;
	localparam logic [3:0] ALU_XOR = 4'd3;

	// Condition codes for jXX and cmovXX.
	localparam logic [3:0] C_ALWAYS = 4'd0;
	localparam logic [3:0] C_LE     = 4'd1;
	localparam logic [3:0] C_L      = 4'd2;
	localparam logic [3:0] C_E      = 4'd3;
	localparam logic [3:0] C_NE     = 4'd4;
	localparam logic [3:0] C_GE     = 4'd5;
	localparam logic [3:0] C_G      = 4'd6;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [3:0] REG_NONE = 4'd15;

	localparam logic [WORD_W-1:0] STACK_DEC = WORD_W'(-8);
	localparam logic [WORD_W-1:0] STACK_INC = WORD_W'(8);

	// Condition flags, laid out as bit 2 OF, bit 1 SF, bit 0 ZF.
	typedef struct packed {
		logic of;
		logic sf;
		logic zf;
	} flags_t;

	localparam flags_t FLAGS_CLEAR = '{of: 1'b0, sf: 1'b0, zf: 1'b0};

endpackage

// ----- rtl/core/y86_alu.sv -----
// ----------------------------------------------------------------------------
// y86_alu - operand selection and ALU
// Picks the A and B operands from the icode, runs the ALU and forms new flags.
// ----------------------------------------------------------------------------
module y86_alu import y86_pkg::*; (
	input  logic [3:0]        cmd,
	input  logic [3:0]        func,
	input  logic [WORD_W-1:0] val_a,
	input  logic [WORD_W-1:0] val_b,
	input  logic [WORD_W-1:0] val_c,
	output logic [WORD_W-1:0] result,
	output flags_t            flags_new
);

	logic [WORD_W-1:0] op_a;
	logic [WORD_W-1:0] op_b;
	logic [3:0]        alu_fn;
	logic              sa;
	logic              sb;
	logic              sr;

	always_comb begin
		case (cmd) inside
			I_RRMOVQ, I_OPQ:            op_a = val_a;
			I_IRMOVQ, I_RMMOVQ, I_MRMOVQ: op_a = val_c;
			I_CALL, I_PUSHQ:            op_a = STACK_DEC;
			I_RET, I_POPQ:              op_a = STACK_INC;
			default:                    op_a = '0;
		endcase
		case (cmd) inside
			I_RMMOVQ, I_MRMOVQ, I_OPQ, I_CALL, I_RET, I_PUSHQ, I_POPQ: op_b = val_b;
			default: op_b = '0;
		endcase
	end

	assign alu_fn = (cmd == I_OPQ) ? func : ALU_ADD;

	always_comb begin
		case (alu_fn)
			ALU_ADD: result = op_a + op_b;
			ALU_SUB: result = op_b - op_a;
			ALU_AND: result = op_a & op_b;
			ALU_XOR: result = op_a ^ op_b;
			default: result = '0;
		endcase
	end

	assign sa = op_a[WORD_W-1];
	assign sb = op_b[WORD_W-1];
	assign sr = result[WORD_W-1];

	// Overflow is only defined for add and subtract; logic ops clear it.
	always_comb begin
		flags_new.zf = (result == '0);
		flags_new.sf = sr;
		case (alu_fn)
			ALU_ADD: flags_new.of = (sa == sb) && (sr != sa);
			ALU_SUB: flags_new.of = (sa != sb) && (sr != sb);
			default: flags_new.of = 1'b0;
		endcase
	end

endmodule

// ----- rtl/core/y86_cond.sv -----
// ----------------------------------------------------------------------------
// y86_cond - branch and conditional-move condition
// Evaluates the condition from the stored flags and cancels an untaken cmove.
// ----------------------------------------------------------------------------
module y86_cond import y86_pkg::*; (
	input  logic [3:0] cmd,
	input  logic [3:0] func,
	input  flags_t     flags,
	input  logic [3:0] dest_e,
	output logic       cond_true,
	output logic [3:0] dest_e_fwd
);

	logic lt;
	logic hit;

	assign lt = flags.sf ^ flags.of;

	always_comb begin
		case (func)
			C_ALWAYS: hit = 1'b1;
			C_LE:     hit = lt | flags.zf;
			C_L:      hit = lt;
			C_E:      hit = flags.zf;
			C_NE:     hit = ~flags.zf;
			C_GE:     hit = ~lt;
			C_G:      hit = ~lt & ~flags.zf;
			default:  hit = 1'b0;
		endcase
	end

	assign cond_true  = hit && ((cmd == I_RRMOVQ) || (cmd == I_JXX));
	assign dest_e_fwd = ((cmd == I_RRMOVQ) && !cond_true) ? REG_NONE : dest_e;

endmodule

// ----- rtl/core/y86_execute_stage.sv -----
// ----------------------------------------------------------------------------
// y86_execute_stage - Y86-64 pipeline execute stage
// Input register, ALU and condition logic, output register and flag register.
// ----------------------------------------------------------------------------
// Every transaction passes through the input register and then the output
// register, and a new transaction can be taken in every cycle while in_stall
// is low, so the sustained rate is one per clock. The clock period is bounded
// by the single combinational pass from the input register through the 64-bit
// ALU and the condition logic into the output register. The condition flags
// are written as a transaction leaves the input register, so each jump or
// cmove sees the flags left by every earlier OPq that did not fault, in order.
// in_stall is raised only when the input register is full and its contents
// cannot move on because the output register holds a result that is stalled.
module y86_execute_stage import y86_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        in_status,
	input  logic [3:0]        cmd,
	input  logic [3:0]        func,
	input  logic [WORD_W-1:0] val_c,
	input  logic [WORD_W-1:0] val_a,
	input  logic [WORD_W-1:0] val_b,
	input  logic [3:0]        dest_e,
	input  logic [3:0]        dest_m,
	input  logic [1:0]        mem_status,
	input  logic [1:0]        wb_status,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        out_status,
	output logic [3:0]        out_cmd,
	output logic              cond_true,
	output logic [WORD_W-1:0] alu_result,
	output logic [WORD_W-1:0] pass_val_a,
	output logic [3:0]        out_dest_e,
	output logic [3:0]        out_dest_m,
	output logic              bubble_mem
);

	// Input register.
	logic              valid_s1;
	logic [1:0]        status_s1;
	logic [3:0]        cmd_s1;
	logic [3:0]        func_s1;
	logic [WORD_W-1:0] val_c_s1;
	logic [WORD_W-1:0] val_a_s1;
	logic [WORD_W-1:0] val_b_s1;
	logic [3:0]        dest_e_s1;
	logic [3:0]        dest_m_s1;
	logic              fault_s1;

	// Output register.
	logic              valid_s2;
	logic [1:0]        status_s2;
	logic [3:0]        cmd_s2;
	logic              cond_s2;
	logic [WORD_W-1:0] result_s2;
	logic [WORD_W-1:0] val_a_s2;
	logic [3:0]        dest_e_s2;
	logic [3:0]        dest_m_s2;
	logic              bubble_s2;

	flags_t            flags_q;
	flags_t            flags_new;
	logic [WORD_W-1:0] result;
	logic              cond_hit;
	logic [3:0]        dest_e_fwd;
	logic              take_in;
	logic              adv_s1;

	// The input register moves on whenever the output register is empty or
	// its result is being taken in this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// A fault in either later stage is folded into one bit at capture; it
	// both blocks the flag update and requests the memory-stage bubble.
	always_ff @(posedge clk) begin
		if (take_in) begin
			status_s1 <= in_status;
			cmd_s1    <= cmd;
			func_s1   <= func;
			val_c_s1  <= val_c;
			val_a_s1  <= val_a;
			val_b_s1  <= val_b;
			dest_e_s1 <= dest_e;
			dest_m_s1 <= dest_m;
			fault_s1  <= (mem_status != STAT_OK) || (wb_status != STAT_OK);
		end
	end

	y86_alu u_alu (
		.cmd       (cmd_s1),
		.func      (func_s1),
		.val_a     (val_a_s1),
		.val_b     (val_b_s1),
		.val_c     (val_c_s1),
		.result    (result),
		.flags_new (flags_new)
	);

	// Conditions use the flags as they stand before this transaction; an OPq
	// never evaluates a condition, so its own update need not be bypassed.
	y86_cond u_cond (
		.cmd        (cmd_s1),
		.func       (func_s1),
		.flags      (flags_q),
		.dest_e     (dest_e_s1),
		.cond_true  (cond_hit),
		.dest_e_fwd (dest_e_fwd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_CLEAR;
		end else if (adv_s1 && (cmd_s1 == I_OPQ) && !fault_s1) begin
			flags_q <= flags_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= status_s1;
			cmd_s2    <= cmd_s1;
			cond_s2   <= cond_hit;
			result_s2 <= result;
			val_a_s2  <= val_a_s1;
			dest_e_s2 <= dest_e_fwd;
			dest_m_s2 <= dest_m_s1;
			bubble_s2 <= fault_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_status = status_s2;
	assign out_cmd    = cmd_s2;
	assign cond_true  = cond_s2;
	assign alu_result = result_s2;
	assign pass_val_a = val_a_s2;
	assign out_dest_e = dest_e_s2;
	assign out_dest_m = dest_m_s2;
	assign bubble_mem = bubble_s2;

endmodule

// ----- rtl/core/y86_exec_chk.sv -----
// ----------------------------------------------------------------------------
// y86_exec_chk - port-level checker for the execute stage
// Watches the result channel for handshake and decode consistency.
// ----------------------------------------------------------------------------
module y86_exec_chk import y86_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [3:0]        out_cmd,
	input logic              cond_true,
	input logic [3:0]        out_dest_e,
	input logic [WORD_W-1:0] alu_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(alu_result) && $stable(out_dest_e))
		else $error("stalled result changed");

	a_cond_scope: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_cmd != I_RRMOVQ) && (out_cmd != I_JXX) |-> !cond_true)
		else $error("condition raised for an instruction without one");

	a_cmov_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_cmd == I_RRMOVQ) && !cond_true |-> out_dest_e == REG_NONE)
		else $error("untaken cmove kept its destination");

	a_no_operand: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_cmd == I_HALT) || (out_cmd == I_NOP)) |-> alu_result == '0)
		else $error("nonzero ALU result for halt or nop");

endmodule

bind y86_execute_stage y86_exec_chk u_exec_chk (.*);
